### sv/dcar_pkg.sv
// Package with shared types and constants of the DNS client address responder.
`default_nettype none
package dcar_pkg;

    // Request store geometry.
    localparam int BUF_BYTES = 512;
    localparam int AW        = $clog2(BUF_BYTES);

    // Request length limits and fixed offsets.
    localparam logic [15:0] MIN_LEN  = 16'd19;
    localparam logic [15:0] MAX_LEN  = 16'd273;
    localparam logic [AW-1:0] QSTART = AW'(12);
    localparam logic [7:0]  HDR_FLAG = 8'h81;
    localparam logic [7:0]  OPC_MASK = 8'h78;

    // Reply status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FORMERR = 2'd1;
    localparam logic [1:0] ST_NOTIMP  = 2'd2;
    localparam logic [1:0] ST_REFUSED = 2'd3;

    // Pointer operations.
    typedef enum logic [1:0] {
        PTR_HOLD,
        PTR_CLR,
        PTR_INC,
        PTR_QSTART
    } ptr_op_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        ptr_op_t ptr_op;
        logic    cap_hdr;
        logic    chk_pre;
        logic    chk_end;
        logic    chk_null;
        logic    put;
        logic    push;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pkt_ok;
        logic is_last;
        logic pre_err;
        logic at_end;
        logic is_null;
        logic byte_last;
        logic beat_full;
        logic beat_last;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

### sv/dcar_req_if.sv
// Request channel interface: one request byte with its framing and address.
`default_nettype none
interface dcar_req_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [63:0] client_addr_high;
    logic [63:0] client_addr_low;

    modport source (output valid, data_byte, last_byte, client_addr_high, client_addr_low,
                    input ready);
    modport sink (input valid, data_byte, last_byte, client_addr_high, client_addr_low,
                  output ready);
endinterface
`default_nettype wire

### sv/dcar_rsp_if.sv
// Reply channel interface: one reply beat of up to eight bytes.
`default_nettype none
interface dcar_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] reply_beat;
    logic [3:0]  beat_bytes;
    logic        last_beat;
    logic [1:0]  reply_status;

    modport source (output valid, reply_beat, beat_bytes, last_beat, reply_status,
                    input ready);
    modport sink (input valid, reply_beat, beat_bytes, last_beat, reply_status,
                  output ready);
endinterface
`default_nettype wire

### sv/dcar_datapath.sv
// Datapath: request store, length counter, question scan and reply beat builder.
`default_nettype none
module dcar_datapath
    import dcar_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    input  wire logic [63:0] client_addr_high,
    input  wire logic [63:0] client_addr_low,
    input  wire cmd_t        cmd,
    output sts_t             sts,
    dcar_rsp_if.source       rsp
);

    logic [7:0]    mem [BUF_BYTES];
    logic [7:0]    rdata_reg;
    logic [15:0]   len_reg, len_next, len_inc;
    logic [15:0]   flen_reg;
    logic          cfg_reg;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [7:0]    id0_reg, id1_reg, opc_reg;
    logic [63:0]   hi_reg, lo_reg;
    logic [1:0]    status_reg;
    logic [AW-1:0] qend_reg;
    logic [63:0]   beat_reg;
    logic [3:0]    cnt_reg;
    logic          blast_reg;
    logic          out_valid_reg;
    logic [63:0]   out_beat_reg;
    logic [3:0]    out_bytes_reg;
    logic          out_last_reg;
    logic [1:0]    out_status_reg;
    logic          v4;
    logic [127:0]  addr128;
    logic [AW-1:0] nlen;
    logic [AW-1:0] ans_idx;
    logic [7:0]    ans_byte;
    logic [7:0]    hdr_byte;
    logic [7:0]    cur_byte;
    logic [7:0]    rcode;
    logic [5:0]    align_sh;

    // Saturating length count of the request being loaded.
    assign len_inc = (len_reg == 16'hFFFF) ? len_reg : len_reg + 16'd1;
    assign len_next = cmd.load ? (last_byte ? 16'd0 : len_inc) : len_reg;

    // Store write and registered read.
    always_ff @(posedge clk)
    begin
        if (cmd.load && (len_reg < 16'(BUF_BYTES)))
        begin
            mem[len_reg[AW-1:0]] <= data_byte;
        end
        rdata_reg <= mem[ptr_reg];
    end

    // Pointer update.
    always_comb
    begin
        case (cmd.ptr_op)
            PTR_HOLD:   ptr_next = ptr_reg;
            PTR_CLR:    ptr_next = '0;
            PTR_INC:    ptr_next = ptr_reg + AW'(1);
            PTR_QSTART: ptr_next = QSTART;
            default:    ptr_next = ptr_reg;
        endcase
    end

    // Address family and reply length.
    assign v4 = cfg_reg || ((hi_reg == 64'd0) && (lo_reg[63:32] == 32'h0000FFFF));
    assign addr128 = v4 ? {lo_reg[31:0], 96'd0} : {hi_reg, lo_reg};
    assign nlen = (status_reg != ST_OK) ? AW'(12) : (qend_reg + (v4 ? AW'(16) : AW'(28)));

    // Answer section bytes.
    assign ans_idx = ptr_reg - qend_reg;
    always_comb
    begin
        logic [127:0] sh;
        sh = addr128 << {ans_idx[3:0] - 4'd12, 3'b000};
        case (ans_idx[4:0])
            5'd0:    ans_byte = 8'hC0;
            5'd1:    ans_byte = 8'h0C;
            5'd3:    ans_byte = v4 ? 8'h01 : 8'h1C;
            5'd5:    ans_byte = 8'h01;
            5'd11:   ans_byte = v4 ? 8'h04 : 8'h10;
            5'd2, 5'd4, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10:
                     ans_byte = 8'h00;
            default: ans_byte = sh[127:120];
        endcase
    end

    // Header bytes.
    always_comb
    begin
        case (status_reg)
            ST_FORMERR: rcode = 8'h01;
            ST_NOTIMP:  rcode = 8'h04;
            ST_REFUSED: rcode = 8'h05;
            default:    rcode = 8'h00;
        endcase
        case (ptr_reg[3:0])
            4'd0:    hdr_byte = id0_reg;
            4'd1:    hdr_byte = id1_reg;
            4'd2:    hdr_byte = HDR_FLAG;
            4'd3:    hdr_byte = rcode;
            4'd5:    hdr_byte = (status_reg == ST_OK) ? 8'h01 : 8'h00;
            4'd7:    hdr_byte = (status_reg == ST_OK) ? 8'h01 : 8'h00;
            default: hdr_byte = 8'h00;
        endcase
    end

    // Reply byte at the current pointer.
    always_comb
    begin
        if (ptr_reg < AW'(12))
        begin
            cur_byte = hdr_byte;
        end
        else if (ptr_reg < qend_reg)
        begin
            cur_byte = rdata_reg;
        end
        else
        begin
            cur_byte = ans_byte;
        end
    end

    assign align_sh = {3'(4'd8 - cnt_reg), 3'b000};

    // Status to the controller.
    always_comb
    begin
        sts.pkt_ok    = (len_inc >= MIN_LEN);
        sts.is_last   = last_byte;
        sts.pre_err   = (flen_reg > MAX_LEN) || ((opc_reg & OPC_MASK) != 8'h00);
        sts.at_end    = (16'(ptr_reg) == flen_reg);
        sts.is_null   = (rdata_reg == 8'h00);
        sts.byte_last = (ptr_reg == nlen - AW'(1));
        sts.beat_full = (cnt_reg == 4'd7);
        sts.beat_last = blast_reg;
        sts.out_free  = !out_valid_reg || rsp.ready;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            cfg_reg       <= 1'b0;
            ptr_reg       <= '0;
            status_reg    <= ST_OK;
            cnt_reg       <= '0;
            blast_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg <= len_next;
            ptr_reg <= ptr_next;
            if (cfg_we)
            begin
                cfg_reg <= cfg_wdata;
            end
            if (cmd.chk_pre)
            begin
                if (flen_reg > MAX_LEN)
                begin
                    status_reg <= ST_REFUSED;
                end
                else if ((opc_reg & OPC_MASK) != 8'h00)
                begin
                    status_reg <= ST_NOTIMP;
                end
                else
                begin
                    status_reg <= ST_OK;
                end
            end
            if (cmd.chk_null && ((ptr_reg <= AW'(13)) ||
                                 ((16'(ptr_reg) + 16'd4) >= flen_reg)))
            begin
                status_reg <= ST_FORMERR;
            end
            if (cmd.put)
            begin
                cnt_reg   <= cnt_reg + 4'd1;
                blast_reg <= sts.byte_last;
            end
            if (cmd.push)
            begin
                cnt_reg       <= '0;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load && last_byte)
        begin
            flen_reg <= len_inc;
            hi_reg   <= client_addr_high;
            lo_reg   <= client_addr_low;
        end
        if (cmd.cap_hdr)
        begin
            case (ptr_reg[1:0])
                2'd1:    id0_reg <= rdata_reg;
                2'd2:    id1_reg <= rdata_reg;
                default: opc_reg <= rdata_reg;
            endcase
        end
        if (cmd.chk_end)
        begin
            qend_reg <= flen_reg[AW-1:0];
        end
        if (cmd.chk_null)
        begin
            qend_reg <= ptr_reg + AW'(5);
        end
        if (cmd.put)
        begin
            beat_reg <= {beat_reg[55:0], cur_byte};
        end
        if (cmd.push)
        begin
            out_beat_reg   <= beat_reg << align_sh;
            out_bytes_reg  <= cnt_reg;
            out_last_reg   <= blast_reg;
            out_status_reg <= status_reg;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.reply_beat   = out_beat_reg;
    assign rsp.beat_bytes   = out_bytes_reg;
    assign rsp.last_beat    = out_last_reg;
    assign rsp.reply_status = out_status_reg;

endmodule
`default_nettype wire

### sv/dcar_ctrl.sv
// Controller: sequences request loading, header fetch, question scan and reply emission.
`default_nettype none
module dcar_ctrl
    import dcar_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_H0,
        S_H1,
        S_H2,
        S_H3,
        S_PRE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_E_RD,
        S_E_PUT,
        S_E_OUT
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.ptr_op = PTR_HOLD;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cmd.ptr_op = PTR_CLR;
                    if (sts.is_last && sts.pkt_ok)
                    begin
                        state_next = S_H0;
                    end
                end
            end
            S_H0:
            begin
                cmd.ptr_op = PTR_INC;
                state_next = S_H1;
            end
            S_H1, S_H2:
            begin
                cmd.cap_hdr = 1'b1;
                cmd.ptr_op  = PTR_INC;
                state_next  = (state_reg == S_H1) ? S_H2 : S_H3;
            end
            S_H3:
            begin
                cmd.cap_hdr = 1'b1;
                state_next  = S_PRE;
            end
            S_PRE:
            begin
                cmd.chk_pre = 1'b1;
                if (sts.pre_err)
                begin
                    cmd.ptr_op = PTR_CLR;
                    state_next = S_E_RD;
                end
                else
                begin
                    cmd.ptr_op = PTR_QSTART;
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                if (sts.at_end)
                begin
                    cmd.chk_end = 1'b1;
                    cmd.ptr_op  = PTR_CLR;
                    state_next  = S_E_RD;
                end
                else
                begin
                    state_next = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK:
            begin
                if (sts.is_null)
                begin
                    cmd.chk_null = 1'b1;
                    cmd.ptr_op   = PTR_CLR;
                    state_next   = S_E_RD;
                end
                else
                begin
                    cmd.ptr_op = PTR_INC;
                    state_next = S_SCAN_RD;
                end
            end
            S_E_RD:
            begin
                state_next = S_E_PUT;
            end
            S_E_PUT:
            begin
                cmd.put    = 1'b1;
                cmd.ptr_op = PTR_INC;
                state_next = (sts.byte_last || sts.beat_full) ? S_E_OUT : S_E_RD;
            end
            S_E_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = sts.beat_last ? S_IDLE : S_E_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

### sv/dns_client_address_responder.sv
// Top level of the DNS client address responder.
// Request bytes are taken one per cycle while the block is idle and written
// into a 512-byte store. On the final byte the block reads the first three
// request bytes and checks them and the request length, scans the question
// byte by byte for its null, and then builds the reply byte by byte, handing
// out a beat of up to eight bytes through an output register. The scan runs to
// the end of the request when there is no null, and is skipped when the header
// already gives an error. The single-port store read sets the pace of the scan
// and of the reply. No new request is taken until the last beat sits in the
// output register. The user must write the socket family bit only while the
// block is idle; the block itself does not enforce this.
`default_nettype none
module dns_client_address_responder
    import dcar_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_we,
    input  wire logic cfg_wdata,
    dcar_req_if.sink   req,
    dcar_rsp_if.source rsp
);

    cmd_t cmd;
    sts_t sts;
    logic in_ready;

    assign req.ready = in_ready;

    // Sequencer.
    dcar_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Store and reply builder.
    dcar_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .data_byte        (req.data_byte),
        .last_byte        (req.last_byte),
        .client_addr_high (req.client_addr_high),
        .client_addr_low  (req.client_addr_low),
        .cmd              (cmd),
        .sts              (sts),
        .rsp              (rsp)
    );

endmodule
`default_nettype wire
